>>> src/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int CMD_W   = 3;
  localparam int DT_W    = 16;
  localparam int SPEED_W = 16;
  localparam int DUR_W   = 24;
  localparam int CNT_W   = 9;
  localparam int FRAME_W = 8;
  localparam int TIMER_W = 25;
  // Q4.12 speed: product is shifted right by the fraction width
  localparam int FRAC_W  = 12;
  localparam int INC_W   = DT_W + SPEED_W - FRAC_W;

  localparam int IDX_W   = 3;
  localparam int WDATA_W = 24;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_DURATION = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOOP     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PINGPONG = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPEED    = 3'd4;

  // Register reset values
  localparam logic [DUR_W-1:0]   DUR_RST   = 24'd6554;
  localparam logic [CNT_W-1:0]   CNT_RST   = 9'd0;
  localparam logic [SPEED_W-1:0] SPEED_RST = 16'd4096;

  // 0.0001 s in 1/65536 s units, rounded down
  localparam logic [DUR_W-1:0]   DUR_MIN   = 24'd6;
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  typedef struct packed {
    logic [DUR_W-1:0]   frame_duration;
    logic [CNT_W-1:0]   frame_count;
    logic               loop_enable;
    logic               pingpong_enable;
    logic [SPEED_W-1:0] playback_speed;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [INC_W-1:0] inc;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic               playing;
    logic               reversing;
  } result_t;

endpackage

>>> src/sfs_cfg.sv
// ----------------------------------------------------------------------------
// sfs_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sfs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wen,
  input  logic [sfs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::WDATA_W-1:0] cfg_wdata,
  output sfs_pkg::cfg_t               cfg
);
  import sfs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_duration  <= DUR_RST;
      cfg_r.frame_count     <= CNT_RST;
      cfg_r.loop_enable     <= 1'b1;
      cfg_r.pingpong_enable <= 1'b0;
      cfg_r.playback_speed  <= SPEED_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DURATION: cfg_r.frame_duration  <= cfg_wdata[DUR_W-1:0];
        REG_COUNT:    cfg_r.frame_count     <= cfg_wdata[CNT_W-1:0];
        REG_LOOP:     cfg_r.loop_enable     <= cfg_wdata[0];
        REG_PINGPONG: cfg_r.pingpong_enable <= cfg_wdata[0];
        REG_SPEED:    cfg_r.playback_speed  <= cfg_wdata[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/sfs_core.sv
// ----------------------------------------------------------------------------
// sfs_core
// Playback state and frame stepping; the state registers are the result.
// ----------------------------------------------------------------------------
module sfs_core #(
  parameter int MAX_FRAMES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sfs_pkg::cfg_t    cfg,
  input  logic             go,
  input  sfs_pkg::item_t   item,
  output sfs_pkg::result_t res
);
  import sfs_pkg::*;

  localparam int                CNT_LIM_I = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam logic [CNT_W-1:0]  CNT_LIM   = CNT_W'(CNT_LIM_I);

  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               play_r, play_nxt;
  logic               bwd_r, bwd_nxt;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_m2;
  logic [CNT_W-1:0]   frame_p1;
  logic               tick_ok;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sat;
  logic               due;
  logic [FRAME_W-1:0] step_frame;
  logic               step_bwd;
  logic               step_play;

  always_comb begin
    cnt      = (cfg.frame_count > CNT_LIM) ? CNT_LIM : cfg.frame_count;
    cnt_m1   = cnt - 9'd1;
    cnt_m2   = cnt - 9'd2;
    frame_p1 = {1'b0, frame_r} + 9'd1;
    tick_ok  = play_r && (cfg.playback_speed != '0) &&
               (cfg.frame_duration > DUR_MIN) && (cnt >= 9'd2);

    // saturating timer add, then at most one duration taken off
    sum = {1'b0, timer_r} + (TIMER_W+1)'(item.inc);
    sat = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];
    due = sat >= TIMER_W'(cfg.frame_duration);

    step_frame = frame_r;
    step_bwd   = bwd_r;
    step_play  = play_r;
    if (cfg.pingpong_enable) begin
      if (bwd_r) begin
        if (frame_r != '0) begin
          step_frame = frame_r - 8'd1;
        end else begin
          step_frame = 8'd1;
          step_bwd   = 1'b0;
        end
      end else begin
        if ({1'b0, frame_r} < cnt_m1) begin
          step_frame = frame_p1[FRAME_W-1:0];
        end else begin
          step_frame = cnt_m2[FRAME_W-1:0];
          step_bwd   = 1'b1;
        end
      end
    end else begin
      if (frame_p1 >= cnt) begin
        if (cfg.loop_enable) begin
          step_frame = '0;
        end else begin
          step_frame = cnt_m1[FRAME_W-1:0];
          step_play  = 1'b0;
        end
      end else begin
        step_frame = frame_p1[FRAME_W-1:0];
      end
    end

    timer_nxt = timer_r;
    frame_nxt = frame_r;
    play_nxt  = play_r;
    bwd_nxt   = bwd_r;
    unique case (item.cmd)
      CMD_TICK: begin
        if (tick_ok) begin
          if (due) begin
            timer_nxt = sat - TIMER_W'(cfg.frame_duration);
            frame_nxt = step_frame;
            play_nxt  = step_play;
            bwd_nxt   = step_bwd;
          end else begin
            timer_nxt = sat;
          end
        end
      end
      CMD_PLAY: begin
        timer_nxt = '0;
        frame_nxt = '0;
        play_nxt  = 1'b1;
        bwd_nxt   = 1'b0;
      end
      CMD_PAUSE:  play_nxt = 1'b0;
      CMD_RESUME: play_nxt = 1'b1;
      CMD_STOP: begin
        timer_nxt = '0;
        frame_nxt = '0;
        play_nxt  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      frame_r <= '0;
      play_r  <= 1'b0;
      bwd_r   <= 1'b0;
    end else if (go) begin
      timer_r <= timer_nxt;
      frame_r <= frame_nxt;
      play_r  <= play_nxt;
      bwd_r   <= bwd_nxt;
    end
  end

  assign res.frame_index = frame_r;
  assign res.playing     = play_r;
  assign res.reversing   = bwd_r;

endmodule

>>> src/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Sprite animation frame sequencer: tick, play, pause, resume and stop
// commands drive a frame timer and a ping-pong, loop or play-once stepper.
// ----------------------------------------------------------------------------
// Pipeline: a multiply stage registers the input, then the timer add, compare
// and frame step write the state registers, which feed the next command.
// Throughput: 1 command per cycle unless out_tready stalls the output.
// Reset: synchronous active-low rst_n clears the pipeline valids and the
// playback state and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: cmd [2:0], delta_time [18:3], zero fill [23:19]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sfs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: frame_index [7:0], playing [8], reversing [9], zero fill [15:10]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sfs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_wen,
  input  logic [sfs_pkg::IDX_W-1:0]       cfg_index,
  input  logic [sfs_pkg::WDATA_W-1:0]     cfg_wdata
);
  import sfs_pkg::*;

  cfg_t    cfg;
  item_t   s1_r;
  logic    s1_vld_r;
  logic    out_vld_r;
  logic    s1_adv;
  result_t res;

  logic [DT_W-1:0]          in_dt;
  logic [DT_W+SPEED_W-1:0]  prod;

  sfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_dt  = in_tdata[CMD_W +: DT_W];
  assign prod   = in_dt * cfg.playback_speed;

  // advance stage 1 into the state/result registers when the result slot frees
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_r.cmd <= in_tdata[CMD_W-1:0];
      s1_r.inc <= prod[DT_W+SPEED_W-1:FRAC_W];
    end
  end

  sfs_core #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .go    (s1_adv),
    .item  (s1_r),
    .res   (res)
  );

  // state registers hold still while a result waits, so they serve as the
  // result register
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res.reversing, res.playing, res.frame_index};

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite frame sequencer. A scoreboard predicts
// the frame index, playing and reversing flags for every accepted command and
// compares them with the returned status in order. Playback commands and
// ticks are driven through phases of register settings, including extremes,
// with random gaps on the request side and random stalls on the status side.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfs_pkg::*;

  localparam int MAX_FRAMES  = 256;
  localparam int COUNT_CAP   = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
  localparam int HOLD_CYCLES = 80;
  localparam int N_FIXED     = 10;
  localparam int N_PHASES    = 16;
  localparam int PHASE_ITEMS = 72;

  class frame_scoreboard;
    cfg_t               regs;
    logic [TIMER_W-1:0] timer;
    logic [FRAME_W-1:0] frame;
    logic               active;
    logic               backward;
    result_t            pending_status[$];
    int                 mismatches;

    function new();
      regs = '{DUR_RST, CNT_RST, 1'b1, 1'b0, SPEED_RST};
      timer = '0;
      frame = '0;
      active = 1'b0;
      backward = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [WDATA_W-1:0] value);
      case (idx)
        REG_DURATION: regs.frame_duration = value[DUR_W-1:0];
        REG_COUNT:    regs.frame_count = value[CNT_W-1:0];
        REG_LOOP:     regs.loop_enable = value[0];
        REG_PINGPONG: regs.pingpong_enable = value[0];
        REG_SPEED:    regs.playback_speed = value[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [DT_W-1:0] dt);
      logic [CNT_W-1:0]         n;
      logic [DT_W+SPEED_W-1:0]  prod;
      logic [TIMER_W:0]         sum;
      logic [CNT_W-1:0]         nxt;
      result_t                  r;
      n = regs.frame_count;
      if (n > COUNT_CAP) n = CNT_W'(COUNT_CAP);
      case (cmd)
        CMD_TICK: begin
          if (active && regs.playback_speed != 0 && regs.frame_duration > DUR_MIN
              && n >= 2) begin
            prod = dt * regs.playback_speed;
            sum = timer + prod[DT_W+SPEED_W-1:FRAC_W];
            timer = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
            // at most one frame step per tick, even if the timer stays ahead
            if (timer >= regs.frame_duration) begin
              timer = timer - regs.frame_duration;
              if (regs.pingpong_enable) begin
                if (backward) begin
                  if (frame != 0) frame = frame - 1'b1;
                  else begin
                    backward = 1'b0;
                    frame = 1;
                  end
                end else if (frame < n - 1) begin
                  frame = frame + 1'b1;
                end else begin
                  backward = 1'b1;
                  frame = FRAME_W'(n - 2);
                end
              end else begin
                nxt = frame + 1;
                if (nxt >= n) begin
                  if (regs.loop_enable) nxt = 0;
                  else begin
                    nxt = n - 1;
                    active = 1'b0;
                  end
                end
                frame = nxt[FRAME_W-1:0];
              end
            end
          end
        end
        CMD_PLAY: begin
          frame = '0;
          timer = '0;
          active = 1'b1;
          backward = 1'b0;
        end
        CMD_PAUSE:  active = 1'b0;
        CMD_RESUME: active = 1'b1;
        CMD_STOP: begin
          active = 1'b0;
          frame = '0;
          timer = '0;
        end
        default: ;
      endcase
      r.frame_index = frame;
      r.playing = active;
      r.reversing = backward;
      pending_status.push_back(r);
    endfunction

    function void compare_status(logic [OUT_TDATA_W-1:0] d);
      result_t want;
      if (pending_status.size() == 0) begin
        $error("status with no pending request: frame_index=%0d playing=%0d reversing=%0d",
               d[7:0], d[8], d[9]);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (d[7:0] !== want.frame_index) begin
          $error("frame_index: expected %0d, got %0d", want.frame_index, d[7:0]);
          mismatches++;
        end
        if (d[8] !== want.playing) begin
          $error("playing: expected %0d, got %0d", want.playing, d[8]);
          mismatches++;
        end
        if (d[9] !== want.reversing) begin
          $error("reversing: expected %0d, got %0d", want.reversing, d[9]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wen;
  logic [IDX_W-1:0]       cfg_index;
  logic [WDATA_W-1:0]     cfg_wdata;

  bit hold_rx = 1'b0;
  bit no_gaps = 1'b0;

  frame_scoreboard sb = new();

  cfg_t phase_cfg [N_FIXED] = '{
    '{24'd6554,     9'd8,   1'b1, 1'b0, 16'd4096},
    '{24'd6554,     9'd8,   1'b0, 1'b0, 16'd4096},
    '{24'd3000,     9'd5,   1'b1, 1'b1, 16'd4096},
    '{24'd7,        9'd2,   1'b0, 1'b1, 16'd65535},
    '{24'd6,        9'd16,  1'b1, 1'b0, 16'd4096},
    '{24'd16777215, 9'd256, 1'b1, 1'b0, 16'd65535},
    '{24'd1000,     9'd256, 1'b0, 1'b1, 16'd8192},
    '{24'd500,      9'd3,   1'b1, 1'b1, 16'd4096},
    '{24'd0,        9'd1,   1'b0, 1'b0, 16'd0},
    '{24'd20000,    9'd511, 1'b1, 1'b1, 16'd1}
  };

  sprite_frame_sequencer #(
    .MAX_FRAMES(MAX_FRAMES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.compare_status(out_tdata);
  end

  // status side: random stalls per status word, plus one long hold on request
  initial begin : status_sink
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // valid stays high on return so back-to-back requests need no extra edge
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [DT_W-1:0] dt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, dt, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, dt);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    logic [IDX_W-1:0]   idx;
    logic [WDATA_W-1:0] data;
    for (int i = 0; i < 5; i++) begin
      idx = IDX_W'(i);
      case (idx)
        REG_DURATION: data = c.frame_duration;
        REG_COUNT:    data = WDATA_W'(c.frame_count);
        REG_LOOP:     data = WDATA_W'(c.loop_enable);
        REG_PINGPONG: data = WDATA_W'(c.pingpong_enable);
        default:      data = WDATA_W'(c.playback_speed);
      endcase
      cfg_wen <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      sb.write_reg(idx, data);
    end
    cfg_wen <= 1'b0;
  endtask

  initial begin : request_source
    cfg_t               c;
    int                 r;
    logic [CMD_W-1:0]   cmd;
    logic [DT_W-1:0]    dt;
    longint             t;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_wen <= 1'b0;
    cfg_index <= REG_DURATION;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no frames, so ticks must be dropped
    send_cmd(CMD_PLAY, 16'd0);
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_PAUSE, 16'd0);
    send_cmd(CMD_RESUME, 16'd0);
    send_cmd(CMD_STOP, 16'd0);
    send_cmd(3'd5, 16'hAAAA);
    send_cmd(3'd6, 16'h5555);
    send_cmd(3'd7, 16'hFFFF);
    drain();

    // play-once over three frames: exact hit, overshoot, clamp and stop
    load_config('{24'd6554, 9'd3, 1'b0, 1'b0, 16'd4096});
    send_cmd(CMD_PLAY, 16'd0);
    send_cmd(CMD_TICK, 16'd6553);
    send_cmd(CMD_TICK, 16'd1);
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_RESUME, 16'd0);
    send_cmd(CMD_TICK, 16'd0);
    send_cmd(CMD_PAUSE, 16'd0);
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_RESUME, 16'd0);
    send_cmd(CMD_STOP, 16'd0);
    send_cmd(3'd7, 16'hFFFF);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < N_FIXED) begin
        c = phase_cfg[p];
      end else begin
        case ($urandom_range(0, 2))
          0: c.frame_duration = DUR_W'($urandom_range(0, 16));
          1: c.frame_duration = DUR_W'($urandom_range(7, 70000));
          default: c.frame_duration = DUR_W'($urandom());
        endcase
        case ($urandom_range(0, 2))
          0: c.frame_count = CNT_W'($urandom_range(0, 3));
          1: c.frame_count = CNT_W'($urandom_range(0, 511));
          default: c.frame_count = CNT_W'($urandom_range(2, 12));
        endcase
        c.loop_enable = 1'($urandom_range(0, 1));
        c.pingpong_enable = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: c.playback_speed = '0;
          1: c.playback_speed = 16'hFFFF;
          2: c.playback_speed = 16'd4096;
          default: c.playback_speed = SPEED_W'($urandom());
        endcase
      end
      // keep the running frame across some phases so it can land past the count
      load_config(c);
      no_gaps = (p % 4 == 1);
      if ($urandom_range(0, 1)) send_cmd(CMD_PLAY, DT_W'($urandom()));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == 20) hold_rx = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 80) cmd = CMD_TICK;
        else if (r < 86) cmd = CMD_RESUME;
        else if (r < 90) cmd = CMD_PAUSE;
        else if (r < 94) cmd = CMD_PLAY;
        else if (r < 97) cmd = CMD_STOP;
        else cmd = CMD_W'($urandom_range(5, 7));
        case ($urandom_range(0, 3))
          0: dt = DT_W'($urandom());
          1: dt = DT_W'($urandom_range(0, 31));
          default: begin
            // aim near one frame, or a fraction of one, per tick
            if (sb.regs.playback_speed == 0) begin
              dt = DT_W'($urandom());
            end else begin
              t = (longint'(sb.regs.frame_duration) << FRAC_W) / sb.regs.playback_speed;
              t = t / $urandom_range(1, 4) + $urandom_range(0, 2);
              dt = (t > 65535) ? 16'hFFFF : DT_W'(t);
            end
          end
        endcase
        send_cmd(cmd, dt);
      end
      drain();
    end

    no_gaps = 1'b0;
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
